// ===== hdl/tam_pkg.sv =====
package tam_pkg;

    // Codes carried in the action field of an input item.
    typedef enum logic [1:0] {
        ACT_UP     = 2'd0,
        ACT_DOWN   = 2'd1,
        ACT_SAMPLE = 2'd2
    } t_action;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ALARM_STEP   = 3'd0,
        REG_PRESS_GAP_MS = 3'd1,
        REG_SETPOINT_MAX = 3'd2,
        REG_LEVEL_ONE    = 3'd3,
        REG_LEVEL_TWO    = 3'd4,
        REG_LEVEL_THREE  = 3'd5,
        REG_LEVEL_FOUR   = 3'd6
    } t_cfg_reg;

    localparam logic [6:0]  RST_ALARM_STEP   = 7'd5;
    localparam logic [15:0] RST_PRESS_GAP_MS = 16'd200;
    localparam logic [6:0]  RST_SETPOINT_MAX = 7'd100;
    localparam logic [6:0]  RST_LEVEL_ONE    = 7'd20;
    localparam logic [6:0]  RST_LEVEL_TWO    = 7'd15;
    localparam logic [6:0]  RST_LEVEL_THREE  = 7'd10;
    localparam logic [6:0]  RST_LEVEL_FOUR   = 7'd2;
    localparam logic [6:0]  RST_SETPOINT     = 7'd25;

    typedef struct packed {
        logic [6:0]  alarm_step;
        logic [15:0] press_gap_ms;
        logic [6:0]  setpoint_max;
        logic [6:0]  level_one;
        logic [6:0]  level_two;
        logic [6:0]  level_three;
        logic [6:0]  level_four;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        time_ms;
        logic signed [11:0] temperature;
    } t_item;

    typedef struct packed {
        logic [6:0] setpoint;
        logic [3:0] leds;
        logic       buzzer;
        logic       alarm_active;
    } t_result;

endpackage

// ===== hdl/tam_if.sv =====
interface tam_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [31:0]        time_ms;
    logic signed [11:0] temperature;

    modport source (output valid, output action, output time_ms, output temperature,
                    input ready);
    modport sink (input valid, input action, input time_ms, input temperature,
                  output ready);
endinterface

interface tam_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] setpoint;
    logic [3:0] leds;
    logic       buzzer;
    logic       alarm_active;

    modport source (output valid, output setpoint, output leds, output buzzer,
                    output alarm_active, input ready);
    modport sink (input valid, input setpoint, input leds, input buzzer,
                  input alarm_active, output ready);
endinterface

interface tam_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tam_cfg_regs.sv =====
module tam_cfg_regs
    import tam_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tam_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_step   <= RST_ALARM_STEP;
            r_cfg.press_gap_ms <= RST_PRESS_GAP_MS;
            r_cfg.setpoint_max <= RST_SETPOINT_MAX;
            r_cfg.level_one    <= RST_LEVEL_ONE;
            r_cfg.level_two    <= RST_LEVEL_TWO;
            r_cfg.level_three  <= RST_LEVEL_THREE;
            r_cfg.level_four   <= RST_LEVEL_FOUR;
        end else if (i_cfg.valid) begin
            // Writes to an index beyond the list are dropped.
            unique case (i_cfg.index)
                REG_ALARM_STEP:   r_cfg.alarm_step   <= i_cfg.data[6:0];
                REG_PRESS_GAP_MS: r_cfg.press_gap_ms <= i_cfg.data;
                REG_SETPOINT_MAX: r_cfg.setpoint_max <= i_cfg.data[6:0];
                REG_LEVEL_ONE:    r_cfg.level_one    <= i_cfg.data[6:0];
                REG_LEVEL_TWO:    r_cfg.level_two    <= i_cfg.data[6:0];
                REG_LEVEL_THREE:  r_cfg.level_three  <= i_cfg.data[6:0];
                REG_LEVEL_FOUR:   r_cfg.level_four   <= i_cfg.data[6:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/tam_core.sv =====
module tam_core
    import tam_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [6:0]  r_setpoint, n_setpoint;
    logic [31:0] r_last_up, n_last_up;
    logic [31:0] r_last_down, n_last_down;
    logic        r_blink, n_blink;
    logic        r_buzzer, n_buzzer;
    logic [3:0]  r_leds, n_leds;

    logic [31:0]        up_elapsed;
    logic [31:0]        down_elapsed;
    logic               up_ok;
    logic               down_ok;
    logic [7:0]         up_sum;
    logic signed [13:0] sp16;
    logic signed [13:0] temp_ext;
    logic signed [13:0] margin16;
    logic               at_alarm;

    function automatic logic margin_ok(logic signed [13:0] margin, logic [6:0] level);
        logic signed [13:0] lvl16;
        lvl16 = $signed({3'b000, level, 4'b0000});
        return margin <= lvl16;
    endfunction

    // Debounce uses the wrapping difference of the 32-bit timestamps.
    assign up_elapsed   = i_item.time_ms - r_last_up;
    assign down_elapsed = i_item.time_ms - r_last_down;
    assign up_ok        = up_elapsed > {16'd0, i_cfg.press_gap_ms};
    assign down_ok      = down_elapsed > {16'd0, i_cfg.press_gap_ms};
    assign up_sum       = {1'b0, r_setpoint} + {1'b0, i_cfg.alarm_step};

    // Setpoint in 1/16 degree so that the compare with the sample is exact.
    assign sp16     = $signed({3'b000, r_setpoint, 4'b0000});
    assign temp_ext = {{2{i_item.temperature[11]}}, i_item.temperature};
    assign at_alarm = temp_ext >= sp16;
    assign margin16 = sp16 - temp_ext;

    always_comb begin
        n_setpoint  = r_setpoint;
        n_last_up   = r_last_up;
        n_last_down = r_last_down;
        n_blink     = r_blink;
        n_buzzer    = r_buzzer;
        n_leds      = r_leds;
        unique case (t_action'(i_item.action))
            ACT_UP: begin
                if (up_ok) begin
                    n_last_up  = i_item.time_ms;
                    n_setpoint = (up_sum > {1'b0, i_cfg.setpoint_max}) ?
                                 i_cfg.setpoint_max : up_sum[6:0];
                end
            end
            ACT_DOWN: begin
                if (down_ok) begin
                    n_last_down = i_item.time_ms;
                    n_setpoint  = (r_setpoint > i_cfg.alarm_step) ?
                                  r_setpoint - i_cfg.alarm_step : 7'd0;
                end
            end
            ACT_SAMPLE: begin
                if (at_alarm) begin
                    n_buzzer = 1'b1;
                    n_blink  = ~r_blink;
                    n_leds   = {4{~r_blink}};
                end else begin
                    n_buzzer = 1'b0;
                    n_leds   = {margin_ok(margin16, i_cfg.level_four),
                                margin_ok(margin16, i_cfg.level_three),
                                margin_ok(margin16, i_cfg.level_two),
                                margin_ok(margin16, i_cfg.level_one)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= RST_SETPOINT;
            r_last_up   <= '0;
            r_last_down <= '0;
            r_blink     <= 1'b0;
            r_buzzer    <= 1'b0;
            r_leds      <= '0;
        end else if (i_step) begin
            r_setpoint  <= n_setpoint;
            r_last_up   <= n_last_up;
            r_last_down <= n_last_down;
            r_blink     <= n_blink;
            r_buzzer    <= n_buzzer;
            r_leds      <= n_leds;
        end
    end

    // The result reports the state as it stands after this item.
    assign o_result.setpoint     = n_setpoint;
    assign o_result.leds         = n_leds;
    assign o_result.buzzer       = n_buzzer;
    assign o_result.alarm_active = n_buzzer;

    a_up_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.action == ACT_UP && up_ok)
        |=> (r_setpoint <= $past(i_cfg.setpoint_max)))
        else $error("setpoint above maximum after an accepted up press");

    a_alarm_leds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzzer |-> (r_leds == 4'h0 || r_leds == 4'hF))
        else $error("partial LED pattern while the buzzer is on");

    a_blink_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && i_item.action == ACT_SAMPLE && at_alarm) |=> $stable(r_blink))
        else $error("blink bit changed without an alarm sample");

endmodule

// ===== hdl/temperature_alarm_monitor.sv =====
// Channel   Role    Handshake          Payload
// i_item    sink    valid / ready      action, time_ms, temperature
// o_result  source  valid / ready      setpoint, leds, buzzer, alarm_active
// i_cfg     sink    valid / ready(=1)  index, data
//
// Each item gives one result: it passes through the input register, then the
// state update and the result register.
// A new item can be taken in every cycle while results drain; the single
// state update per cycle in the core sets that rate of one item per clock.
// Reset is synchronous and active low; it restores the register defaults and
// the state, and empties both pipeline registers.
// When the result sink stalls, the result register holds, and the input
// register accepts one more item before the input side stalls in turn.
module temperature_alarm_monitor
    import tam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tam_item_if.sink    i_item,
    tam_result_if.source o_result,
    tam_cfg_if.sink     i_cfg
);

    // Input stage. The payload needs no reset, only the valid flag does.
    logic  r_in_valid;
    t_item r_in;

    // Result stage.
    logic    r_out_valid;
    t_result r_out;

    t_cfg    cfg;
    t_result core_result;
    logic    advance;

    // The input stage moves forward whenever the result register is free
    // or its content is being taken in this cycle.
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in.action      <= i_item.action;
            r_in.time_ms     <= i_item.time_ms;
            r_in.temperature <= i_item.temperature;
        end
    end

    tam_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // The core holds the setpoint, press times and LED state. It commits the
    // item held in the input register when the stage advances and presents
    // the updated state as this item's result.
    tam_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.setpoint     = r_out.setpoint;
    assign o_result.leds         = r_out.leds;
    assign o_result.buzzer       = r_out.buzzer;
    assign o_result.alarm_active = r_out.alarm_active;

endmodule

// ===== bench/tam_alarm_checker.sv =====
`timescale 1ns / 100ps

module tam_alarm_checker
    import tam_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  logic               i_item_ready,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_time_ms,
    input  logic signed [11:0] i_temperature,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [6:0]         i_setpoint,
    input  logic [3:0]         i_leds,
    input  logic               i_buzzer,
    input  logic               i_alarm_active,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_pending,
    output int                 o_errors
);

    localparam int PRINT_CAP = 50;

    t_cfg       alarm_cfg;
    logic [6:0] setpoint_q;
    logic [31:0] last_up_ms;
    logic [31:0] last_down_ms;
    logic       blink_q;
    logic       buzzer_q;
    logic [3:0] led_q;

    t_result    expected_status[$];
    int         mismatches = 0;

    assign o_errors = mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Advances the alarm state by one item and returns the status it reports.
    function automatic t_result advance_alarm(input logic [1:0] action,
                                              input logic [31:0] now_ms,
                                              input logic signed [11:0] temp);
        logic [31:0] elapsed;
        logic [7:0]  raised;
        int          sp16;
        int          margin;
        t_result     status;
        case (action)
            ACT_UP: begin
                elapsed = now_ms - last_up_ms;
                if (elapsed > {16'd0, alarm_cfg.press_gap_ms}) begin
                    last_up_ms = now_ms;
                    raised = {1'b0, setpoint_q} + {1'b0, alarm_cfg.alarm_step};
                    setpoint_q = (raised > {1'b0, alarm_cfg.setpoint_max}) ?
                                 alarm_cfg.setpoint_max : raised[6:0];
                end
            end
            ACT_DOWN: begin
                elapsed = now_ms - last_down_ms;
                if (elapsed > {16'd0, alarm_cfg.press_gap_ms}) begin
                    last_down_ms = now_ms;
                    setpoint_q = (setpoint_q > alarm_cfg.alarm_step) ?
                                 setpoint_q - alarm_cfg.alarm_step : 7'd0;
                end
            end
            ACT_SAMPLE: begin
                sp16 = int'(setpoint_q) * 16;
                if (int'(temp) >= sp16) begin
                    buzzer_q = 1'b1;
                    blink_q  = ~blink_q;
                    led_q    = blink_q ? 4'hF : 4'h0;
                end else begin
                    margin   = sp16 - int'(temp);
                    buzzer_q = 1'b0;
                    led_q    = {margin <= int'(alarm_cfg.level_four) * 16,
                                margin <= int'(alarm_cfg.level_three) * 16,
                                margin <= int'(alarm_cfg.level_two) * 16,
                                margin <= int'(alarm_cfg.level_one) * 16};
                end
            end
            default: ;
        endcase
        status.setpoint     = setpoint_q;
        status.leds         = led_q;
        status.buzzer       = buzzer_q;
        status.alarm_active = buzzer_q;
        return status;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            alarm_cfg    = t_cfg'{RST_ALARM_STEP, RST_PRESS_GAP_MS, RST_SETPOINT_MAX,
                                  RST_LEVEL_ONE, RST_LEVEL_TWO, RST_LEVEL_THREE,
                                  RST_LEVEL_FOUR};
            setpoint_q   = RST_SETPOINT;
            last_up_ms   = '0;
            last_down_ms = '0;
            blink_q      = 1'b0;
            buzzer_q     = 1'b0;
            led_q        = '0;
            expected_status.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ALARM_STEP:   alarm_cfg.alarm_step   = i_cfg_data[6:0];
                    REG_PRESS_GAP_MS: alarm_cfg.press_gap_ms = i_cfg_data;
                    REG_SETPOINT_MAX: alarm_cfg.setpoint_max = i_cfg_data[6:0];
                    REG_LEVEL_ONE:    alarm_cfg.level_one    = i_cfg_data[6:0];
                    REG_LEVEL_TWO:    alarm_cfg.level_two    = i_cfg_data[6:0];
                    REG_LEVEL_THREE:  alarm_cfg.level_three  = i_cfg_data[6:0];
                    REG_LEVEL_FOUR:   alarm_cfg.level_four   = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("result setpoint %0d with nothing pending",
                                              i_setpoint));
                end else begin
                    want = expected_status.pop_front();
                    if (i_setpoint !== want.setpoint)
                        report_mismatch($sformatf("setpoint got %0d, expected %0d",
                                                  i_setpoint, want.setpoint));
                    if (i_leds !== want.leds)
                        report_mismatch($sformatf("leds got %h, expected %h",
                                                  i_leds, want.leds));
                    if (i_buzzer !== want.buzzer)
                        report_mismatch($sformatf("buzzer got %b, expected %b",
                                                  i_buzzer, want.buzzer));
                    if (i_alarm_active !== want.alarm_active)
                        report_mismatch($sformatf("alarm_active got %b, expected %b",
                                                  i_alarm_active, want.alarm_active));
                end
            end
            if (i_item_valid && i_item_ready) begin
                expected_status.push_back(advance_alarm(i_action, i_time_ms, i_temperature));
            end
        end
        o_pending = expected_status.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

// Top of the alarm monitor bench. This module only makes stimulus and gives
// the verdict; the checker beside the block follows every transfer on the
// three channels, predicts each status result and compares it.
module tb;
    import tam_pkg::*;

    // Far above the slowest correct run.
    localparam int         CYCLE_LIMIT  = 200000;
    // Length of the long receiver hold-off that fills the pipeline.
    localparam int         HOLD_CYCLES  = 64;
    localparam int         PHASE_ITEMS  = 115;
    localparam int         SQUEEZE_ITEMS = 40;
    // Codes outside the defined sets, which the block must ignore.
    localparam logic [1:0] ACT_SPARE     = 2'd3;
    localparam logic [2:0] REG_SPARE     = 3'd7;

    logic        i_clk;
    logic        i_rst_n;

    tam_item_if   item_ch ();
    tam_result_if result_ch ();
    tam_cfg_if    cfg_ch ();

    int          pending;
    int          errors;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_ready = 1'b0;
    logic [6:0]  seen_setpoint = RST_SETPOINT;
    logic [15:0] cur_debounce = RST_PRESS_GAP_MS;
    logic [31:0] clock_ms = '0;

    temperature_alarm_monitor i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    tam_alarm_checker u_status_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (item_ch.valid),
        .i_item_ready   (item_ch.ready),
        .i_action       (item_ch.action),
        .i_time_ms      (item_ch.time_ms),
        .i_temperature  (item_ch.temperature),
        .i_res_valid    (result_ch.valid),
        .i_res_ready    (result_ch.ready),
        .i_setpoint     (result_ch.setpoint),
        .i_leds         (result_ch.leds),
        .i_buzzer       (result_ch.buzzer),
        .i_alarm_active (result_ch.alarm_active),
        .i_cfg_valid    (cfg_ch.valid),
        .i_cfg_ready    (cfg_ch.ready),
        .i_cfg_index    (cfg_ch.index),
        .i_cfg_data     (cfg_ch.data),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result receiver. It stalls at the rate of the current phase, and holds
    // off completely while the pressure process asks for it. The last setpoint
    // seen is kept so that samples can be aimed around the alarm threshold.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid && result_ch.ready) begin
                seen_setpoint <= result_ch.setpoint;
            end
            result_ch.ready <= hold_ready ? 1'b0 : ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one item and returns at the edge of its transfer. Idle cycles
    // are put in front of the item at the current sender rate; when none are
    // drawn, valid simply stays high from the previous transfer.
    task automatic offer_item(input logic [1:0] action, input logic [31:0] stamp,
                              input logic signed [11:0] temp);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.action      <= action;
        item_ch.time_ms     <= stamp;
        item_ch.temperature <= temp;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // One register write. Valid is left high so that writes run back to back.
    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Writes every register. The unused upper data bits of the narrow
    // registers carry random values, which the block must drop.
    task automatic load_config(input t_cfg c);
        write_reg(REG_ALARM_STEP,   {9'($urandom), c.alarm_step});
        write_reg(REG_PRESS_GAP_MS, c.press_gap_ms);
        write_reg(REG_SETPOINT_MAX, {9'($urandom), c.setpoint_max});
        write_reg(REG_LEVEL_ONE,    {9'($urandom), c.level_one});
        write_reg(REG_LEVEL_TWO,    {9'($urandom), c.level_two});
        write_reg(REG_LEVEL_THREE,  {9'($urandom), c.level_three});
        write_reg(REG_LEVEL_FOUR,   {9'($urandom), c.level_four});
        cfg_ch.valid <= 1'b0;
        cur_debounce = c.press_gap_ms;
        @(posedge i_clk);
    endtask

    // Waits until every predicted result has been seen, then lets the two
    // pipeline stages settle. The count is read at the falling edge, after
    // the checker has handled the rising one.
    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.alarm_step   = 7'($urandom_range(127));
        c.press_gap_ms = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
        c.setpoint_max = 7'($urandom_range(127, 30));
        c.level_one    = 7'($urandom_range(60));
        c.level_two    = 7'($urandom_range(40));
        c.level_three  = 7'($urandom_range(20));
        c.level_four   = 7'($urandom_range(8));
        return c;
    endfunction

    // Mostly well formed traffic: button presses on a running millisecond
    // clock that steps around the debounce window, so that presses land on
    // both sides of it, and samples, half of them aimed near the current
    // threshold. A small share is noise with any action code and raw fields.
    task automatic random_item();
        int                 pick;
        int                 offset;
        logic signed [11:0] temp;
        pick   = $urandom_range(99);
        offset = $urandom_range(80) - 40;
        if ($urandom_range(19) == 0) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = clock_ms + $urandom_range(2 * cur_debounce + 2);
        end
        if ($urandom_range(1) == 1) begin
            temp = 12'(int'(seen_setpoint) * 16 + offset);
        end else begin
            temp = 12'($urandom_range(2687) - 640);
        end
        if (pick < 6) begin
            offer_item(2'($urandom), $urandom, 12'($urandom));
        end else if (pick < 32) begin
            offer_item(ACT_UP, clock_ms, 12'($urandom));
        end else if (pick < 58) begin
            offer_item(ACT_DOWN, clock_ms, 12'($urandom));
        end else begin
            offer_item(ACT_SAMPLE, $urandom, temp);
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.action      = ACT_SAMPLE;
        item_ch.time_ms     = '0;
        item_ch.temperature = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_ALARM_STEP;
        cfg_ch.data         = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset settings: setpoint 25, which is 400 in
        // sixteenths of a degree, step 5, debounce 200 ms.
        offer_item(ACT_SAMPLE, $urandom, -12'sd640);   // coldest, far below
        offer_item(ACT_SAMPLE, $urandom, 12'sd2047);   // hottest, alarm, blink on
        offer_item(ACT_SAMPLE, $urandom, 12'sd400);    // exactly at setpoint, blink off
        offer_item(ACT_SAMPLE, $urandom, 12'sd399);    // just below, all LEDs
        offer_item(ACT_SAMPLE, $urandom, 12'sd368);    // margin on the fourth level
        offer_item(ACT_SAMPLE, $urandom, 12'sd367);    // one past it
        offer_item(ACT_SAMPLE, $urandom, 12'sd240);    // margin on the third level
        // Early presses: the last press time starts at zero.
        offer_item(ACT_UP, 32'd100, 12'($urandom));
        offer_item(ACT_UP, 32'd200, 12'($urandom));    // exactly the window, rejected
        offer_item(ACT_UP, 32'd201, 12'($urandom));
        offer_item(ACT_UP, 32'd401, 12'($urandom));
        offer_item(ACT_UP, 32'd402, 12'($urandom));
        // Down presses across the wrap of the millisecond clock.
        offer_item(ACT_DOWN, 32'hFFFF_FFFF, 12'($urandom));
        offer_item(ACT_DOWN, 32'd100, 12'($urandom));
        offer_item(ACT_DOWN, 32'd202, 12'($urandom));
        offer_item(ACT_SPARE, $urandom, 12'($urandom));
        item_ch.valid <= 1'b0;
        wait_drained();

        // Large step, no debounce, widest setpoint maximum; the unused index is
        // written once and must change nothing.
        load_config(t_cfg'{7'd100, 16'd0, 7'd127, 7'd127, 7'd0, 7'd127, 7'd0});
        write_reg(REG_SPARE, 16'hFFFF);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        offer_item(ACT_UP, 32'd1, 12'($urandom));
        offer_item(ACT_UP, 32'd1, 12'($urandom));      // same millisecond, rejected
        offer_item(ACT_UP, 32'd2, 12'($urandom));      // saturates at the maximum
        offer_item(ACT_SAMPLE, $urandom, 12'sd2032);
        offer_item(ACT_SAMPLE, $urandom, 12'sd2031);
        item_ch.valid <= 1'b0;
        wait_drained();

        // Zero step: the press is taken but the setpoint does not move.
        load_config(t_cfg'{7'd0, 16'd65535, 7'd127, 7'd20, 7'd15, 7'd10, 7'd2});
        offer_item(ACT_UP, 32'd70000, 12'($urandom));
        offer_item(ACT_UP, 32'd70001, 12'($urandom));
        item_ch.valid <= 1'b0;
        wait_drained();

        // Maximum lowered under the setpoint: a down press only subtracts,
        // the next up press clamps, then the floor at zero.
        load_config(t_cfg'{7'd1, 16'd0, 7'd0, 7'd20, 7'd15, 7'd10, 7'd2});
        offer_item(ACT_DOWN, 32'd80000, 12'($urandom));
        offer_item(ACT_UP, 32'd80001, 12'($urandom));
        offer_item(ACT_DOWN, 32'd80002, 12'($urandom));
        item_ch.valid <= 1'b0;
        wait_drained();

        // Random phases, each with its own idling pattern and settings. The
        // second uses step 1, no debounce and zero levels; the third the largest.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            if (phase == 1) begin
                load_config(t_cfg'{7'd1, 16'd0, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0});
            end else if (phase == 2) begin
                load_config(t_cfg'{7'd127, 16'd65535, 7'd127, 7'd127, 7'd127, 7'd127,
                                   7'd127});
            end else begin
                load_config(random_cfg());
            end
            repeat (PHASE_ITEMS) random_item();
            item_ch.valid <= 1'b0;
            wait_drained();
        end

        // Pressure: the receiver holds off for a long stretch while items keep
        // coming every cycle, so the result and input registers fill and the
        // block has to stall its input.
        send_idle_pct = 0;
        stall_pct     = 0;
        load_config(random_cfg());
        fork
            begin
                hold_ready <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_ready <= 1'b0;
            end
        join_none
        repeat (SQUEEZE_ITEMS) random_item();
        item_ch.valid <= 1'b0;
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tam_pkg.sv
hdl/tam_if.sv
hdl/tam_cfg_regs.sv
hdl/tam_core.sv
hdl/temperature_alarm_monitor.sv
bench/tam_alarm_checker.sv
bench/tb.sv
